// ===== sv/jds_pkg.sv =====
// Shared types, codes and beat layouts for the job dispatch scheduler.
package jds_pkg;

    typedef logic [31:0] word_t;
    typedef logic [1:0]  code_t;

    localparam code_t OP_SUBMIT   = 2'd0;
    localparam code_t OP_DISPATCH = 2'd1;
    localparam code_t OP_COMPLETE = 2'd2;

    localparam code_t JS_WAITING  = 2'd0;
    localparam code_t JS_PRINTING = 2'd1;
    localparam code_t JS_DONE     = 2'd2;
    localparam code_t JS_FAILED   = 2'd3;

    localparam code_t RC_OK     = 2'd0;
    localparam code_t RC_FULL   = 2'd1;
    localparam code_t RC_EMPTY  = 2'd2;
    localparam code_t RC_BADJOB = 2'd3;

    localparam code_t POL_FIFO = 2'd0;
    localparam code_t POL_SJF  = 2'd1;

    localparam logic CFG_POLICY    = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int ID_W       = 4;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 40;
    localparam int M_USED_W  = 38;

    localparam logic [31:0] AGING_RESET = 32'd50;

endpackage

// ===== sv/job_dispatch_scheduler.sv =====
// Job table with FIFO, shortest-job-first and aged dispatch over a shared scan comparator.
// Path from accept to m_tvalid: submit or unknown op go straight to RESULT, complete via
// CHECK and RESULT, dispatch via SCAN (one table entry per cycle), DRAIN, PICK and RESULT,
// or straight to RESULT if nothing waits; m_tvalid is registered as RESULT is left.
// One beat at a time: the next is accepted after the result loads; RESULT waits out stalls.
// Reset: synchronous, active low; clears counters, policy, threshold (50) and m_tvalid.
module job_dispatch_scheduler #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // op[1:0], size[33:2], target_job[37:34], failed[38], now[70:39]
    input  logic [jds_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // result_code[1:0], job_id[5:2], chosen_size[37:6]
    output logic [jds_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_we,
    input  logic [jds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [jds_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int UW = AW + 1;
    localparam int CW = (UW > jds_pkg::ID_W) ? UW : jds_pkg::ID_W;

    localparam logic [2:0] FSM_IDLE   = 3'd0;
    localparam logic [2:0] FSM_CHECK  = 3'd1;
    localparam logic [2:0] FSM_SCAN   = 3'd2;
    localparam logic [2:0] FSM_DRAIN  = 3'd3;
    localparam logic [2:0] FSM_PICK   = 3'd4;
    localparam logic [2:0] FSM_RESULT = 3'd5;

    logic [2:0]           fsm_reg, fsm_next;
    logic [1:0]           policy_reg;
    jds_pkg::word_t       thr_reg;
    logic [UW-1:0]        used_reg, used_next;
    logic [UW-1:0]        wait_reg, wait_next;
    logic [AW-1:0]        scan_reg, scan_next;

    jds_pkg::code_t       state_mem [TABLE_DEPTH];
    jds_pkg::word_t       size_mem  [TABLE_DEPTH];
    jds_pkg::word_t       arr_mem   [TABLE_DEPTH];

    jds_pkg::code_t       rd_state_reg;
    jds_pkg::word_t       rd_size_reg;
    jds_pkg::word_t       rd_arr_reg;
    logic [AW-1:0]        rd_addr;

    logic                 eval_reg;
    logic [AW-1:0]        eval_idx_reg;

    logic                 first_found_reg, best_found_reg, aged_found_reg;
    logic [AW-1:0]        first_idx_reg, best_idx_reg, aged_idx_reg;
    jds_pkg::word_t       first_size_reg, best_size_reg, aged_size_reg;

    jds_pkg::word_t       now_reg;
    logic [jds_pkg::ID_W-1:0] target_reg;
    logic                 failed_reg;

    jds_pkg::code_t       res_code_reg, res_code_next;
    logic [jds_pkg::ID_W-1:0] res_id_reg, res_id_next;
    jds_pkg::word_t       res_size_reg, res_size_next;

    logic                 m_tvalid_reg;
    logic [jds_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic                 s_acc, out_free;
    logic                 st_we, job_we;
    logic [AW-1:0]        st_waddr;
    jds_pkg::code_t       st_wdata;

    logic                 pick_found;
    logic [AW-1:0]        pick_idx;
    jds_pkg::word_t       pick_size;
    logic                 rd_wait, size_less, age_over;
    jds_pkg::word_t       age;

    jds_pkg::code_t           in_op;
    jds_pkg::word_t           in_size;
    logic [jds_pkg::ID_W-1:0] in_target;
    logic                     in_failed;
    jds_pkg::word_t           in_now;

    assign in_op     = s_tdata[1:0];
    assign in_size   = s_tdata[33:2];
    assign in_target = s_tdata[37:34];
    assign in_failed = s_tdata[38];
    assign in_now    = s_tdata[70:39];

    assign s_tready = (fsm_reg == FSM_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign rd_addr   = (fsm_reg == FSM_SCAN) ? scan_reg : AW'(in_target);
    assign rd_wait   = (rd_state_reg == jds_pkg::JS_WAITING);
    assign size_less = (rd_size_reg < best_size_reg);
    assign age       = now_reg - rd_arr_reg;
    assign age_over  = (age > thr_reg);

    always_comb begin
        case (policy_reg)
            jds_pkg::POL_FIFO: begin
                pick_found = first_found_reg;
                pick_idx   = first_idx_reg;
                pick_size  = first_size_reg;
            end
            jds_pkg::POL_SJF: begin
                pick_found = best_found_reg;
                pick_idx   = best_idx_reg;
                pick_size  = best_size_reg;
            end
            default: begin
                if (aged_found_reg) begin
                    pick_found = 1'b1;
                    pick_idx   = aged_idx_reg;
                    pick_size  = aged_size_reg;
                end else begin
                    pick_found = best_found_reg;
                    pick_idx   = best_idx_reg;
                    pick_size  = best_size_reg;
                end
            end
        endcase
    end

    always_comb begin
        fsm_next      = fsm_reg;
        used_next     = used_reg;
        wait_next     = wait_reg;
        scan_next     = scan_reg;
        res_code_next = res_code_reg;
        res_id_next   = res_id_reg;
        res_size_next = res_size_reg;
        st_we         = 1'b0;
        job_we        = 1'b0;
        st_waddr      = AW'(used_reg);
        st_wdata      = jds_pkg::JS_WAITING;
        unique case (fsm_reg)
            FSM_IDLE: begin
                if (s_acc) begin
                    res_code_next = jds_pkg::RC_BADJOB;
                    res_id_next   = '0;
                    res_size_next = '0;
                    fsm_next      = FSM_RESULT;
                    case (in_op)
                        jds_pkg::OP_SUBMIT: begin
                            if (used_reg == UW'(TABLE_DEPTH)) begin
                                res_code_next = jds_pkg::RC_FULL;
                            end else begin
                                st_we         = 1'b1;
                                job_we        = 1'b1;
                                used_next     = used_reg + UW'(1);
                                wait_next     = wait_reg + UW'(1);
                                res_code_next = jds_pkg::RC_OK;
                                res_id_next   = jds_pkg::ID_W'(used_reg);
                            end
                        end
                        jds_pkg::OP_DISPATCH: begin
                            if (wait_reg == '0) begin
                                res_code_next = jds_pkg::RC_EMPTY;
                            end else begin
                                scan_next = '0;
                                fsm_next  = FSM_SCAN;
                            end
                        end
                        jds_pkg::OP_COMPLETE: begin
                            fsm_next = FSM_CHECK;
                        end
                        default: begin
                            fsm_next = FSM_RESULT;
                        end
                    endcase
                end
            end
            FSM_CHECK: begin
                res_id_next   = target_reg;
                res_size_next = '0;
                res_code_next = jds_pkg::RC_BADJOB;
                if ((CW'(target_reg) < CW'(used_reg)) &&
                    (rd_state_reg == jds_pkg::JS_PRINTING)) begin
                    st_we         = 1'b1;
                    st_waddr      = AW'(target_reg);
                    st_wdata      = failed_reg ? jds_pkg::JS_FAILED : jds_pkg::JS_DONE;
                    res_code_next = jds_pkg::RC_OK;
                end
                fsm_next = FSM_RESULT;
            end
            FSM_SCAN: begin
                if (({1'b0, scan_reg} + UW'(1)) >= used_reg) begin
                    fsm_next = FSM_DRAIN;
                end else begin
                    scan_next = scan_reg + AW'(1);
                end
            end
            FSM_DRAIN: begin
                fsm_next = FSM_PICK;
            end
            FSM_PICK: begin
                if (pick_found) begin
                    st_we         = 1'b1;
                    st_waddr      = pick_idx;
                    st_wdata      = jds_pkg::JS_PRINTING;
                    wait_next     = wait_reg - UW'(1);
                    res_code_next = jds_pkg::RC_OK;
                    res_id_next   = jds_pkg::ID_W'(pick_idx);
                    res_size_next = pick_size;
                end else begin
                    res_code_next = jds_pkg::RC_EMPTY;
                    res_id_next   = '0;
                    res_size_next = '0;
                end
                fsm_next = FSM_RESULT;
            end
            FSM_RESULT: begin
                if (out_free) begin
                    fsm_next = FSM_IDLE;
                end
            end
            default: begin
                fsm_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg    <= FSM_IDLE;
            used_reg   <= '0;
            wait_reg   <= '0;
            scan_reg   <= '0;
            policy_reg <= jds_pkg::POL_FIFO;
            thr_reg    <= jds_pkg::AGING_RESET;
            eval_reg   <= 1'b0;
        end else begin
            fsm_reg  <= fsm_next;
            used_reg <= used_next;
            wait_reg <= wait_next;
            scan_reg <= scan_next;
            eval_reg <= (fsm_reg == FSM_SCAN);
            if (cfg_we) begin
                unique case (cfg_index)
                    jds_pkg::CFG_POLICY:    policy_reg <= cfg_wdata[1:0];
                    jds_pkg::CFG_THRESHOLD: thr_reg    <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            state_mem[st_waddr] <= st_wdata;
        end
        if (job_we) begin
            size_mem[st_waddr] <= in_size;
            arr_mem[st_waddr]  <= in_now;
        end
        rd_state_reg <= state_mem[rd_addr];
        rd_size_reg  <= size_mem[rd_addr];
        rd_arr_reg   <= arr_mem[rd_addr];
        eval_idx_reg <= scan_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_found_reg <= 1'b0;
            best_found_reg  <= 1'b0;
            aged_found_reg  <= 1'b0;
        end else if (s_acc) begin
            first_found_reg <= 1'b0;
            best_found_reg  <= 1'b0;
            aged_found_reg  <= 1'b0;
        end else if (eval_reg && rd_wait) begin
            if (!first_found_reg) begin
                first_found_reg <= 1'b1;
            end
            if (!best_found_reg || size_less) begin
                best_found_reg <= 1'b1;
            end
            if (!aged_found_reg && age_over) begin
                aged_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            now_reg    <= in_now;
            target_reg <= in_target;
            failed_reg <= in_failed;
        end
        if (eval_reg && rd_wait) begin
            if (!first_found_reg) begin
                first_idx_reg  <= eval_idx_reg;
                first_size_reg <= rd_size_reg;
            end
            if (!best_found_reg || size_less) begin
                best_idx_reg  <= eval_idx_reg;
                best_size_reg <= rd_size_reg;
            end
            if (!aged_found_reg && age_over) begin
                aged_idx_reg  <= eval_idx_reg;
                aged_size_reg <= rd_size_reg;
            end
        end
        res_code_reg <= res_code_next;
        res_id_reg   <= res_id_next;
        res_size_reg <= res_size_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((fsm_reg == FSM_RESULT) && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((fsm_reg == FSM_RESULT) && out_free) begin
            m_tdata_reg <= {{(jds_pkg::M_TDATA_W - jds_pkg::M_USED_W){1'b0}},
                            res_size_reg, res_id_reg, res_code_reg};
        end
    end

endmodule

// ===== sv/jds_checker.sv =====
// Port-level checker for the job dispatch scheduler and its bind.
module jds_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [jds_pkg::M_TDATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again before the current beat finished");

    a_fail_no_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != jds_pkg::RC_OK) |-> (m_tdata[37:6] == '0))
        else $error("failed result carries a job size");

    a_full_no_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tdata[1:0] == jds_pkg::RC_FULL) ||
                     (m_tdata[1:0] == jds_pkg::RC_EMPTY)) |-> (m_tdata[5:2] == '0))
        else $error("full or empty result carries a job id");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

endmodule

bind job_dispatch_scheduler jds_checker u_jds_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the job dispatch scheduler: directed, random and backpressure tests.
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH = 16;
    localparam int HOLD_CYCLES = 250;
    localparam jds_pkg::code_t POL_AGED = 2'd2;
    localparam jds_pkg::code_t POL_SPARE = 2'd3;
    localparam jds_pkg::code_t OP_SPARE = 2'd3;

    typedef struct {
        jds_pkg::code_t  op;
        jds_pkg::word_t  size;
        logic [3:0]      target;
        logic            failed;
        jds_pkg::word_t  now;
    } job_req_t;

    typedef struct {
        jds_pkg::code_t  code;
        logic [3:0]      id;
        jds_pkg::word_t  size;
    } job_resp_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [jds_pkg::S_TDATA_W-1:0]    s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [jds_pkg::M_TDATA_W-1:0]    m_tdata;
    logic                             cfg_we = 1'b0;
    logic [jds_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [jds_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;

    // scheduler state as seen by the predictor
    jds_pkg::code_t  slot_state [DEPTH];
    jds_pkg::word_t  slot_size [DEPTH];
    jds_pkg::word_t  slot_arrival [DEPTH];
    int              slots_taken = 0;
    int              jobs_waiting = 0;
    jds_pkg::code_t  pol = jds_pkg::POL_FIFO;
    jds_pkg::word_t  age_limit = jds_pkg::AGING_RESET;

    job_resp_t       outcome_q [$];
    int              failures = 0;
    bit              steady = 1'b0;
    bit              hold_pending = 1'b0;
    jds_pkg::word_t  now_clock = 32'd1000;

    job_dispatch_scheduler #(.TABLE_DEPTH(DEPTH)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

    task automatic predict_outcome(input job_req_t r, output job_resp_t o);
        int fifo_pick;
        int sjf_pick;
        int aged_pick;
        int pick;
        jds_pkg::word_t age;
        fifo_pick = -1;
        sjf_pick = -1;
        aged_pick = -1;
        pick = -1;
        o = '{code: jds_pkg::RC_BADJOB, id: '0, size: '0};
        case (r.op)
            jds_pkg::OP_SUBMIT: begin
                if (slots_taken >= DEPTH) begin
                    o.code = jds_pkg::RC_FULL;
                end else begin
                    slot_state[slots_taken] = jds_pkg::JS_WAITING;
                    slot_size[slots_taken] = r.size;
                    slot_arrival[slots_taken] = r.now;
                    o.code = jds_pkg::RC_OK;
                    o.id = slots_taken[3:0];
                    slots_taken++;
                    jobs_waiting++;
                end
            end
            jds_pkg::OP_DISPATCH: begin
                for (int i = 0; i < slots_taken; i++) begin
                    if (slot_state[i] == jds_pkg::JS_WAITING) begin
                        age = r.now - slot_arrival[i];
                        if (fifo_pick < 0) fifo_pick = i;
                        if (aged_pick < 0 && age > age_limit) aged_pick = i;
                        if (sjf_pick < 0 || slot_size[i] < slot_size[sjf_pick]) sjf_pick = i;
                    end
                end
                if (jobs_waiting != 0) begin
                    if (pol == jds_pkg::POL_FIFO) pick = fifo_pick;
                    else if (pol == jds_pkg::POL_SJF) pick = sjf_pick;
                    else pick = (aged_pick >= 0) ? aged_pick : sjf_pick;
                end
                if (pick < 0) begin
                    o.code = jds_pkg::RC_EMPTY;
                end else begin
                    slot_state[pick] = jds_pkg::JS_PRINTING;
                    jobs_waiting--;
                    o.code = jds_pkg::RC_OK;
                    o.id = pick[3:0];
                    o.size = slot_size[pick];
                end
            end
            jds_pkg::OP_COMPLETE: begin
                o.id = r.target;
                if (r.target < slots_taken && slot_state[r.target] == jds_pkg::JS_PRINTING) begin
                    slot_state[r.target] = r.failed ? jds_pkg::JS_FAILED : jds_pkg::JS_DONE;
                    o.code = jds_pkg::RC_OK;
                end
            end
            default: begin
            end
        endcase
    endtask

    function automatic job_req_t mk_req(jds_pkg::code_t op, jds_pkg::word_t size,
                                        logic [3:0] target, logic failed,
                                        jds_pkg::word_t now);
        job_req_t r;
        r = '{op: op, size: size, target: target, failed: failed, now: now};
        return r;
    endfunction

    function automatic jds_pkg::word_t tick();
        now_clock = now_clock + $urandom_range(0, 25);
        return now_clock;
    endfunction

    function automatic jds_pkg::word_t pick_size();
        return $urandom_range(0, 1) ? jds_pkg::word_t'($urandom_range(0, 3))
                                    : jds_pkg::word_t'($urandom());
    endfunction

    function automatic int printing_slot();
        int busy [$];
        for (int i = 0; i < slots_taken; i++)
            if (slot_state[i] == jds_pkg::JS_PRINTING) busy.insert(busy.size(), i);
        if (busy.size() == 0) return -1;
        return busy[$urandom_range(0, busy.size() - 1)];
    endfunction

    // random fields throughout; op is noise (never a submit)
    function automatic job_req_t noise_req();
        job_req_t r;
        jds_pkg::code_t ops [3] = '{jds_pkg::OP_DISPATCH, jds_pkg::OP_COMPLETE, OP_SPARE};
        r.op = ops[$urandom_range(0, 2)];
        r.size = $urandom();
        r.target = 4'($urandom_range(0, 15));
        r.failed = 1'($urandom_range(0, 1));
        r.now = ($urandom_range(0, 19) == 0) ? jds_pkg::word_t'($urandom()) : tick();
        return r;
    endfunction

    task automatic send_job(input job_req_t r);
        job_resp_t o;
        int gap;
        if (!steady && $urandom_range(0, 99) < 19) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, r.now, r.failed, r.target, r.size, r.op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_outcome(r, o);
        outcome_q.insert(outcome_q.size(), o);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outcome_q.size() != 0);
    endtask

    task automatic write_reg(input logic [jds_pkg::CFG_IDX_W-1:0] idx,
                             input jds_pkg::word_t val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (idx == jds_pkg::CFG_POLICY) pol = val[1:0];
        else age_limit = val;
    endtask

    task automatic test_directed_basics();
        send_job(mk_req(jds_pkg::OP_DISPATCH, '0, 4'd0, 1'b0, 32'd5));
        send_job(mk_req(jds_pkg::OP_COMPLETE, '0, 4'd15, 1'b1, 32'd6));
        send_job(mk_req(OP_SPARE, '0, 4'd0, 1'b0, 32'd7));
        send_job(mk_req(jds_pkg::OP_SUBMIT, 32'hFFFF_FFFF, 4'd0, 1'b0, 32'd0));
        send_job(mk_req(jds_pkg::OP_SUBMIT, 32'd0, 4'd0, 1'b0, 32'hFFFF_FFFF));
        send_job(mk_req(jds_pkg::OP_SUBMIT, 32'd9, 4'd0, 1'b0, 32'd10));
        send_job(mk_req(jds_pkg::OP_SUBMIT, 32'd9, 4'd0, 1'b0, 32'd20));
        send_job(mk_req(jds_pkg::OP_COMPLETE, '0, 4'd1, 1'b0, 32'd25));
        send_job(mk_req(jds_pkg::OP_DISPATCH, '0, 4'd0, 1'b0, 32'd30));
        send_job(mk_req(jds_pkg::OP_COMPLETE, '0, 4'd0, 1'b1, 32'd31));
        send_job(mk_req(jds_pkg::OP_COMPLETE, '0, 4'd0, 1'b0, 32'd32));
    endtask

    task automatic test_shortest_first();
        drain();
        write_reg(jds_pkg::CFG_POLICY, jds_pkg::word_t'(jds_pkg::POL_SJF));
        send_job(mk_req(jds_pkg::OP_DISPATCH, '0, 4'd0, 1'b0, 32'd40));
        send_job(mk_req(jds_pkg::OP_COMPLETE, '0, 4'd1, 1'b0, 32'd41));
        send_job(mk_req(jds_pkg::OP_DISPATCH, '0, 4'd0, 1'b0, 32'd42));
    endtask

    task automatic test_aging();
        drain();
        write_reg(jds_pkg::CFG_POLICY, jds_pkg::word_t'(POL_AGED));
        write_reg(jds_pkg::CFG_THRESHOLD, 32'd0);
        send_job(mk_req(jds_pkg::OP_SUBMIT, 32'd1, 4'd0, 1'b0, 32'd100));
        send_job(mk_req(jds_pkg::OP_DISPATCH, '0, 4'd0, 1'b0, 32'd100));
        drain();
        write_reg(jds_pkg::CFG_THRESHOLD, 32'hFFFF_FFFF);
        send_job(mk_req(jds_pkg::OP_SUBMIT, 32'd3, 4'd0, 1'b0, 32'd200));
        send_job(mk_req(jds_pkg::OP_DISPATCH, '0, 4'd0, 1'b0, 32'd5));
        drain();
        write_reg(jds_pkg::CFG_POLICY, jds_pkg::word_t'(POL_SPARE));
        write_reg(jds_pkg::CFG_THRESHOLD, jds_pkg::AGING_RESET);
        send_job(mk_req(jds_pkg::OP_DISPATCH, '0, 4'd0, 1'b0, 32'd300));
        send_job(mk_req(jds_pkg::OP_DISPATCH, '0, 4'd0, 1'b0, 32'd301));
    endtask

    task automatic test_random_phase(input jds_pkg::code_t policy, input jds_pkg::word_t limit,
                                     input bit calm, input int count);
        job_req_t r;
        int budget;
        int busy;
        int roll;
        budget = 3;
        drain();
        write_reg(jds_pkg::CFG_POLICY, jds_pkg::word_t'(policy));
        write_reg(jds_pkg::CFG_THRESHOLD, limit);
        steady = calm;
        repeat (count) begin
            r = noise_req();
            roll = $urandom_range(0, 99);
            busy = printing_slot();
            if (roll < 70) begin
                if (budget > 0 && slots_taken < DEPTH && roll < 12) begin
                    r.op = jds_pkg::OP_SUBMIT;
                    r.size = pick_size();
                    r.now = tick();
                    budget--;
                end else if (jobs_waiting != 0 && roll < 40) begin
                    r.op = jds_pkg::OP_DISPATCH;
                end else if (busy >= 0) begin
                    r.op = jds_pkg::OP_COMPLETE;
                    r.target = 4'(busy);
                end else begin
                    r.op = jds_pkg::OP_DISPATCH;
                end
            end
            send_job(r);
        end
        steady = 1'b0;
    endtask

    task automatic test_backpressure();
        job_req_t r;
        hold_pending = 1'b1;
        repeat (40) begin
            r = noise_req();
            send_job(r);
        end
    endtask

    task automatic test_full_table();
        int busy;
        drain();
        write_reg(jds_pkg::CFG_POLICY, jds_pkg::word_t'(POL_AGED));
        write_reg(jds_pkg::CFG_THRESHOLD, $urandom());
        while (slots_taken < DEPTH)
            send_job(mk_req(jds_pkg::OP_SUBMIT, pick_size(), 4'd0, 1'b0, tick()));
        repeat (3) send_job(mk_req(jds_pkg::OP_SUBMIT, pick_size(), 4'd0, 1'b0, tick()));
        while (jobs_waiting != 0) begin
            send_job(mk_req(jds_pkg::OP_DISPATCH, $urandom(), 4'($urandom_range(0, 15)),
                            1'b0, tick()));
            busy = printing_slot();
            if (busy >= 0)
                send_job(mk_req(jds_pkg::OP_COMPLETE, '0, 4'(busy),
                                1'($urandom_range(0, 1)), tick()));
        end
        send_job(mk_req(jds_pkg::OP_DISPATCH, '0, 4'd0, 1'b0, tick()));
        send_job(mk_req(jds_pkg::OP_COMPLETE, '0, 4'd15, 1'b0, tick()));
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_basics();
        test_shortest_first();
        test_aging();
        test_random_phase(jds_pkg::POL_SJF, $urandom(), 1'b0, 130);
        test_random_phase(POL_AGED, $urandom_range(0, 60), 1'b1, 130);
        test_random_phase(jds_pkg::POL_FIFO, $urandom_range(10, 40), 1'b0, 130);
        test_backpressure();
        test_full_table();
        drain();
        repeat (DEPTH + 20) @(posedge aclk);
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= steady || ($urandom_range(0, 99) >= 19);
        end
    end

    always @(posedge aclk) begin
        job_resp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: result beat with none expected, actual %h", $time, m_tdata);
                failures++;
            end else begin
                want = outcome_q.pop_front();
                if (m_tdata[1:0] !== want.code) begin
                    $display("%0t: result_code expected %0d actual %0d",
                             $time, want.code, m_tdata[1:0]);
                    failures++;
                end
                if (m_tdata[5:2] !== want.id) begin
                    $display("%0t: job_id expected %0d actual %0d",
                             $time, want.id, m_tdata[5:2]);
                    failures++;
                end
                if (m_tdata[37:6] !== want.size) begin
                    $display("%0t: chosen_size expected %h actual %h",
                             $time, want.size, m_tdata[37:6]);
                    failures++;
                end
            end
        end
    end

endmodule

// ===== job_dispatch_scheduler.f =====
sv/jds_pkg.sv
sv/job_dispatch_scheduler.sv
sv/jds_checker.sv
tb/tb.sv
